>>> src/sequence_gap_splitter_top_macros.svh
`ifndef SEQUENCE_GAP_SPLITTER_TOP_MACROS_SVH
`define SEQUENCE_GAP_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SGS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sgs_pkg.sv
package sgs_pkg;

    localparam int MAX_BREAK_RUN_DEF = 64;
    localparam int QUEUE_DEPTH_DEF   = 2;

    // wide enough for any N burst up to the largest supported break run
    localparam int N_CNT_W = 7;

    localparam logic [31:0] SAT32           = 32'hFFFF_FFFF;
    localparam logic [6:0]  BREAK_RUN_RESET = 7'd2;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_OPEN  = 2'd2;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_VT  = 8'h0B;
    localparam logic [7:0] CH_FF  = 8'h0C;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_N   = 8'h4E;

    typedef struct packed {
        logic       cmd;
        logic [7:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_out;
        logic [31:0] contig_id;
        logic [31:0] scaffold_id;
        logic [31:0] begin_offset;
        logic [31:0] end_offset;
        logic        last;
    } out_item_t;

    // One classified item: the records and characters it expands into.
    typedef struct packed {
        logic               do_close;
        logic               do_open;
        logic [N_CNT_W-1:0] n_count;
        logic               do_char;
        logic [7:0]         char_val;
        logic [31:0]        close_cid;
        logic [31:0]        close_sid;
        logic [31:0]        close_begin;
        logic [31:0]        close_end;
        logic [31:0]        open_cid;
        logic [31:0]        open_sid;
    } job_t;

    function automatic logic inc_sat_max(input logic [31:0] v);
        return v == SAT32;
    endfunction

    function automatic logic [31:0] inc32(input logic [31:0] v);
        return inc_sat_max(v) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] prev_id(input logic [31:0] v);
        return (v == 32'd0) ? 32'd0 : v - 32'd1;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic logic is_base(input logic [7:0] c);
        logic [7:0] u;
        u = c & 8'hDF;
        return u == 8'h41 || u == 8'h43 || u == 8'h47 || u == 8'h54;
    endfunction

endpackage

>>> src/sgs_front.sv
`include "sequence_gap_splitter_top_macros.svh"

module sgs_front #(
    parameter int MAX_BREAK_RUN = sgs_pkg::MAX_BREAK_RUN_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [6:0]       cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  sgs_pkg::in_item_t in_data,
    output logic             q_push,
    output sgs_pkg::job_t    q_data,
    input  logic             q_ready
);

    localparam int CNT_W = $clog2(MAX_BREAK_RUN + 1);

    logic [6:0]       break_run_reg;
    logic             at_line_start_reg, at_line_start_next;
    logic             in_header_reg, in_header_next;
    logic             header_seen_reg, header_seen_next;
    logic             contig_open_reg, contig_open_next;
    logic             bad_none_reg, bad_none_next;      // bad run is "no base yet"
    logic [CNT_W-1:0] bad_cnt_reg, bad_cnt_next;
    logic             off_neg_reg, off_neg_next;        // offset is minus one
    logic [31:0]      off_reg, off_next;
    logic [31:0]      contig_begin_reg, contig_begin_next;
    logic [31:0]      contig_end_reg, contig_end_next;
    logic [31:0]      contig_count_reg, contig_count_next;
    logic [31:0]      scaffold_count_reg, scaffold_count_next;

    logic [CNT_W-1:0] eff_break;
    logic             accept;
    logic [7:0]       c;
    logic [31:0]      off_inc;
    logic [31:0]      begin_tmp;
    sgs_pkg::job_t    job;

    always_comb
    begin
        if (break_run_reg == 7'd0)
            eff_break = CNT_W'(1);
        else if (break_run_reg > 7'(MAX_BREAK_RUN))
            eff_break = CNT_W'(MAX_BREAK_RUN);
        else
            eff_break = break_run_reg[CNT_W-1:0];
    end

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign c        = in_data.byte_value;
    assign off_inc  = off_neg_reg ? 32'd0 : sgs_pkg::inc32(off_reg);
    assign begin_tmp = contig_open_reg ? contig_begin_reg : off_inc;

    always_comb
    begin
        at_line_start_next  = at_line_start_reg;
        in_header_next      = in_header_reg;
        header_seen_next    = header_seen_reg;
        contig_open_next    = contig_open_reg;
        bad_none_next       = bad_none_reg;
        bad_cnt_next        = bad_cnt_reg;
        off_neg_next        = off_neg_reg;
        off_next            = off_reg;
        contig_begin_next   = contig_begin_reg;
        contig_end_next     = contig_end_reg;
        contig_count_next   = contig_count_reg;
        scaffold_count_next = scaffold_count_reg;
        job                 = '0;

        // default record fields; a base overrides close_begin, a header open_sid
        job.close_cid   = sgs_pkg::prev_id(contig_count_reg);
        job.close_sid   = sgs_pkg::prev_id(scaffold_count_reg);
        job.close_begin = contig_begin_reg;
        job.close_end   = sgs_pkg::inc32(contig_end_reg);
        job.open_cid    = contig_count_reg;
        job.open_sid    = sgs_pkg::prev_id(scaffold_count_reg);
        job.char_val    = c;

        if (accept)
        begin
            if (in_data.cmd == sgs_pkg::CMD_END)
            begin
                job.do_close        = header_seen_reg;
                at_line_start_next  = 1'b1;
                in_header_next      = 1'b0;
                header_seen_next    = 1'b0;
                contig_open_next    = 1'b1;
                bad_none_next       = 1'b1;
                bad_cnt_next        = '0;
                off_neg_next        = 1'b0;
                off_next            = '0;
                contig_begin_next   = '0;
                contig_end_next     = '0;
                contig_count_next   = '0;
                scaffold_count_next = '0;
            end
            else
            begin
                at_line_start_next = (c == sgs_pkg::CH_LF);
                if (c == sgs_pkg::CH_NUL)
                begin
                    // ignored
                end
                else if (in_header_reg)
                begin
                    if (c == sgs_pkg::CH_LF)
                        in_header_next = 1'b0;
                end
                else if (at_line_start_reg && c == sgs_pkg::CH_GT)
                begin
                    job.do_close        = header_seen_reg;
                    job.do_open         = 1'b1;
                    job.open_sid        = sgs_pkg::prev_id(sgs_pkg::inc32(scaffold_count_reg));
                    if (header_seen_reg)
                        contig_end_next = sgs_pkg::inc32(contig_end_reg);
                    header_seen_next    = 1'b1;
                    in_header_next      = 1'b1;
                    contig_open_next    = 1'b0;
                    scaffold_count_next = sgs_pkg::inc32(scaffold_count_reg);
                    contig_count_next   = sgs_pkg::inc32(contig_count_reg);
                    bad_none_next       = 1'b1;
                    bad_cnt_next        = '0;
                    off_neg_next        = 1'b1;
                    off_next            = '0;
                end
                else if (!sgs_pkg::is_space(c))
                begin
                    off_neg_next = 1'b0;
                    off_next     = off_inc;
                    if (sgs_pkg::is_base(c))
                    begin
                        contig_open_next  = 1'b1;
                        contig_begin_next = begin_tmp;
                        job.close_begin   = begin_tmp;
                        if (!bad_none_reg && bad_cnt_reg != '0)
                        begin
                            if (bad_cnt_reg >= eff_break)
                            begin
                                job.do_close      = 1'b1;
                                job.do_open       = 1'b1;
                                contig_count_next = sgs_pkg::inc32(contig_count_reg);
                                contig_begin_next = off_inc;
                            end
                            else
                            begin
                                job.n_count = sgs_pkg::N_CNT_W'(bad_cnt_reg);
                            end
                        end
                        contig_end_next = off_inc;
                        bad_none_next   = 1'b0;
                        bad_cnt_next    = '0;
                        job.do_char     = 1'b1;
                    end
                    else if (!bad_none_reg && bad_cnt_reg < CNT_W'(MAX_BREAK_RUN))
                    begin
                        bad_cnt_next = bad_cnt_reg + CNT_W'(1);
                    end
                end
            end
        end
    end

    assign q_push = accept && (job.do_close || job.do_open || job.do_char);
    assign q_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_run_reg      <= sgs_pkg::BREAK_RUN_RESET;
            at_line_start_reg  <= 1'b1;
            in_header_reg      <= 1'b0;
            header_seen_reg    <= 1'b0;
            contig_open_reg    <= 1'b1;
            bad_none_reg       <= 1'b1;
            bad_cnt_reg        <= '0;
            off_neg_reg        <= 1'b0;
            off_reg            <= '0;
            contig_begin_reg   <= '0;
            contig_end_reg     <= '0;
            contig_count_reg   <= '0;
            scaffold_count_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                break_run_reg <= cfg_wdata;
            at_line_start_reg  <= at_line_start_next;
            in_header_reg      <= in_header_next;
            header_seen_reg    <= header_seen_next;
            contig_open_reg    <= contig_open_next;
            bad_none_reg       <= bad_none_next;
            bad_cnt_reg        <= bad_cnt_next;
            off_neg_reg        <= off_neg_next;
            off_reg            <= off_next;
            contig_begin_reg   <= contig_begin_next;
            contig_end_reg     <= contig_end_next;
            contig_count_reg   <= contig_count_next;
            scaffold_count_reg <= scaffold_count_next;
        end
    end

    `SGS_ASSERT_NOW(a_header_implies_seen, in_header_reg, header_seen_reg, "header without seen flag")
    `SGS_ASSERT_NOW(a_push_has_room, q_push, q_ready, "job pushed into full queue")
    `SGS_ASSERT_NOW(a_bad_cnt_bounded, 1'b1, bad_cnt_reg <= CNT_W'(MAX_BREAK_RUN), "bad run over limit")

endmodule

>>> src/sgs_queue.sv
module sgs_queue #(
    parameter int DEPTH = sgs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  sgs_pkg::job_t push_data,
    output logic          push_ready,
    output logic          pop_valid,
    output sgs_pkg::job_t pop_data,
    input  logic          pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sgs_pkg::job_t    entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

>>> src/sgs_back.sv
`include "sequence_gap_splitter_top_macros.svh"

module sgs_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sgs_pkg::job_t      q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output sgs_pkg::out_item_t out_data
);

    sgs_pkg::job_t               job_reg;
    logic                        job_valid_reg, job_valid_next;
    logic                        rem_close_reg, rem_close_next;
    logic                        rem_open_reg, rem_open_next;
    logic [sgs_pkg::N_CNT_W-1:0] n_left_reg, n_left_next;
    logic                        rem_char_reg, rem_char_next;
    logic                        out_valid_reg, out_valid_next;
    sgs_pkg::out_item_t          out_data_reg, res;
    logic                        advance;

    assign q_pop   = !job_valid_reg && q_valid;
    assign advance = job_valid_reg && (!out_valid_reg || out_ready);

    // pick the next result: close, open, N burst, then the base
    always_comb
    begin
        res            = '0;
        rem_close_next = rem_close_reg;
        rem_open_next  = rem_open_reg;
        n_left_next    = n_left_reg;
        rem_char_next  = rem_char_reg;
        if (rem_close_reg)
        begin
            res.kind         = sgs_pkg::KIND_CLOSE;
            res.contig_id    = job_reg.close_cid;
            res.scaffold_id  = job_reg.close_sid;
            res.begin_offset = job_reg.close_begin;
            res.end_offset   = job_reg.close_end;
            rem_close_next   = 1'b0;
        end
        else if (rem_open_reg)
        begin
            res.kind        = sgs_pkg::KIND_OPEN;
            res.contig_id   = job_reg.open_cid;
            res.scaffold_id = job_reg.open_sid;
            rem_open_next   = 1'b0;
        end
        else if (n_left_reg != '0)
        begin
            res.kind     = sgs_pkg::KIND_CHAR;
            res.char_out = sgs_pkg::CH_N;
            n_left_next  = n_left_reg - sgs_pkg::N_CNT_W'(1);
        end
        else
        begin
            res.kind      = sgs_pkg::KIND_CHAR;
            res.char_out  = job_reg.char_val;
            rem_char_next = 1'b0;
        end
        res.last = !(rem_close_next || rem_open_next || n_left_next != '0 || rem_char_next);
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        out_valid_next = out_valid_reg;
        if (q_pop)
            job_valid_next = 1'b1;
        else if (advance && res.last)
            job_valid_next = 1'b0;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_data;
        if (advance)
            out_data_reg <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            rem_close_reg <= 1'b0;
            rem_open_reg  <= 1'b0;
            n_left_reg    <= '0;
            rem_char_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                rem_close_reg <= q_data.do_close;
                rem_open_reg  <= q_data.do_open;
                n_left_reg    <= q_data.n_count;
                rem_char_reg  <= q_data.do_char;
            end
            else if (advance)
            begin
                rem_close_reg <= rem_close_next;
                rem_open_reg  <= rem_open_next;
                n_left_reg    <= n_left_next;
                rem_char_reg  <= rem_char_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SGS_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !out_data.last, out_valid, "gap inside one item's results")
    `SGS_ASSERT_NOW(a_n_left_in_job, n_left_reg != '0, job_valid_reg, "N count without active job")
    `SGS_ASSERT_NOW(a_no_pop_while_busy, q_pop, !job_valid_reg, "job popped over active job")

endmodule

>>> src/sequence_gap_splitter_top.sv
// Gap splitter for FASTA-style text. Bytes arrive one item at a time
// (cmd 0) and an end-of-input item (cmd 1) closes the last contig, if a
// header was seen, and resets all counters. Bases (ACGT, either case)
// come out unchanged; a run of other symbols shorter than break_run comes
// out as N's just before the next base, while a run of break_run or more
// closes the current contig and opens a new one. A '>' at the start of a
// line starts a header: the line is skipped, the previous contig is closed
// and the first contig of the next scaffold is opened. Records carry the
// contig and scaffold numbers and, for closes, the begin and end offsets.
// Rate: the front end classifies one item per cycle unless the job queue
// (two entries) is full, which stalls the input; items with no results
// never enter it. The back end loads a job, then gives one result per cycle
// while out_ready is high, up to 64 (a 63-symbol N burst plus its base),
// and loads the next job after the last result. Write break_run through
// cfg_we/cfg_wdata only while the block is idle; the block does not check.

module sequence_gap_splitter_top #(
    parameter int MAX_BREAK_RUN = sgs_pkg::MAX_BREAK_RUN_DEF,
    parameter int QUEUE_DEPTH   = sgs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  sgs_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output sgs_pkg::out_item_t out_data
);

    // front -> queue
    logic          q_push;
    logic          q_push_ready;
    sgs_pkg::job_t q_push_data;

    // queue -> back
    logic          q_pop;
    logic          q_pop_valid;
    sgs_pkg::job_t q_pop_data;

    // Front end: item classification, all scaffold/contig state, break_run.
    sgs_front #(
        .MAX_BREAK_RUN (MAX_BREAK_RUN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_push    (q_push),
        .q_data    (q_push_data),
        .q_ready   (q_push_ready)
    );

    // Jobs waiting for the back end; items with no results never enter.
    sgs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data),
        .pop        (q_pop)
    );

    // Back end: expands a job into records and characters, registered output.
    sgs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_pop_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> tb/contig_stream_checker.sv
module contig_stream_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  sgs_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  sgs_pkg::out_item_t out_data,
    output int                 due_count,
    output int                 fault_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_CAP = 64;
    localparam int RUN_CEIL   = sgs_pkg::MAX_BREAK_RUN_DEF;

    // splitter state as seen from outside
    logic [6:0]  gap_setting;
    logic        line_start;
    logic        header_body;
    logic        header_seen;
    logic        contig_live;
    int          bad_len;      // -1 until the first base of a scaffold
    longint      seq_pos;      // -1 right after a header
    logic [31:0] ctg_begin;
    logic [31:0] ctg_end;
    logic [31:0] ctg_num;
    logic [31:0] scf_num;

    sgs_pkg::out_item_t batch[$];
    sgs_pkg::out_item_t due_results[$];
    int                 faults = 0;

    function automatic logic [31:0] sat_up(input logic [31:0] v);
        return (v == sgs_pkg::SAT32) ? v : v + 32'd1;
    endfunction

    function automatic logic [31:0] id_of(input logic [31:0] v);
        return (v == 32'd0) ? 32'd0 : v - 32'd1;
    endfunction

    function automatic logic acgt(input logic [7:0] c);
        case (c)
            "A", "a", "C", "c", "G", "g", "T", "t": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic blank(input logic [7:0] c);
        case (c)
            sgs_pkg::CH_SP, sgs_pkg::CH_TAB, sgs_pkg::CH_LF,
            sgs_pkg::CH_VT, sgs_pkg::CH_FF, sgs_pkg::CH_CR: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // zero acts as one, anything past the ceiling acts as the ceiling
    function automatic int split_threshold();
        if (gap_setting == 7'd0)
            return 1;
        if (int'(gap_setting) > RUN_CEIL)
            return RUN_CEIL;
        return int'(gap_setting);
    endfunction

    task automatic add_result(input logic [1:0] kind, input logic [7:0] ch,
                              input logic [31:0] cid, input logic [31:0] sid,
                              input logic [31:0] b, input logic [31:0] e);
        sgs_pkg::out_item_t r;
        if (batch.size() >= RESULT_CAP)
            return;
        r.kind         = kind;
        r.char_out     = ch;
        r.contig_id    = cid;
        r.scaffold_id  = sid;
        r.begin_offset = b;
        r.end_offset   = e;
        r.last         = 1'b0;
        batch.push_back(r);
    endtask

    task automatic close_contig();
        ctg_end = sat_up(ctg_end);
        add_result(sgs_pkg::KIND_CLOSE, 8'h00, id_of(ctg_num), id_of(scf_num),
                   ctg_begin, ctg_end);
    endtask

    task automatic open_contig();
        add_result(sgs_pkg::KIND_OPEN, 8'h00, ctg_num, id_of(scf_num), 32'd0, 32'd0);
        ctg_num = sat_up(ctg_num);
    endtask

    task automatic clear_splitter();
        line_start  = 1'b1;
        header_body = 1'b0;
        header_seen = 1'b0;
        contig_live = 1'b1;
        bad_len     = -1;
        seq_pos     = 0;
        ctg_begin   = '0;
        ctg_end     = '0;
        ctg_num     = '0;
        scf_num     = '0;
    endtask

    task automatic take_byte(input logic [7:0] c);
        logic        was_start;
        logic [31:0] pos;
        was_start  = line_start;
        line_start = (c == sgs_pkg::CH_LF);
        if (c == sgs_pkg::CH_NUL)
            return;
        if (header_body)
        begin
            if (c == sgs_pkg::CH_LF)
                header_body = 1'b0;
            return;
        end
        if (was_start && c == sgs_pkg::CH_GT)
        begin
            if (header_seen)
                close_contig();
            header_seen = 1'b1;
            header_body = 1'b1;
            contig_live = 1'b0;
            scf_num     = sat_up(scf_num);
            open_contig();
            bad_len = -1;
            seq_pos = -1;
            return;
        end
        if (blank(c))
            return;
        if (seq_pos < longint'(sgs_pkg::SAT32))
            seq_pos++;
        if (acgt(c))
        begin
            pos = seq_pos[31:0];
            if (!contig_live)
            begin
                ctg_begin   = pos;
                contig_live = 1'b1;
            end
            if (bad_len > 0)
            begin
                if (bad_len >= split_threshold())
                begin
                    close_contig();
                    open_contig();
                    ctg_begin = pos;
                end
                else
                begin
                    repeat (bad_len)
                        add_result(sgs_pkg::KIND_CHAR, sgs_pkg::CH_N, '0, '0, '0, '0);
                end
            end
            ctg_end = pos;
            bad_len = 0;
            add_result(sgs_pkg::KIND_CHAR, c, '0, '0, '0, '0);
            return;
        end
        // leading junk of a scaffold is dropped
        if (bad_len < 0)
            return;
        if (bad_len < RUN_CEIL)
            bad_len++;
    endtask

    task automatic advance_splitter(input sgs_pkg::in_item_t it);
        batch.delete();
        if (it.cmd == sgs_pkg::CMD_END)
        begin
            if (header_seen)
                close_contig();
            clear_splitter();
        end
        else
        begin
            take_byte(it.byte_value);
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            due_results.push_back(batch[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sgs_pkg::out_item_t want;
        logic               wrong;
        if (!rst_n)
        begin
            gap_setting = sgs_pkg::BREAK_RUN_RESET;
            clear_splitter();
            due_results.delete();
            due_count <= 0;
        end
        else
        begin
            if (cfg_we)
                gap_setting = cfg_wdata;
            if (in_valid && in_ready)
                advance_splitter(in_data);
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("%0t: unexpected result kind %0d char %h contig %0d",
                                 $realtime, out_data.kind, out_data.char_out,
                                 out_data.contig_id);
                end
                else
                begin
                    want  = due_results.pop_front();
                    wrong = (out_data.kind !== want.kind) ||
                            (out_data.char_out !== want.char_out) ||
                            (out_data.contig_id !== want.contig_id) ||
                            (out_data.scaffold_id !== want.scaffold_id) ||
                            (out_data.begin_offset !== want.begin_offset) ||
                            (out_data.end_offset !== want.end_offset) ||
                            (out_data.last !== want.last);
                    if (wrong)
                    begin
                        faults++;
                        if (faults <= 10)
                        begin
                            $display("%0t: mismatch exp/act kind %0d/%0d char %h/%h %s",
                                     $realtime, want.kind, out_data.kind,
                                     want.char_out, out_data.char_out, "");
                            $display("  contig %0d/%0d scaffold %0d/%0d begin %0d/%0d",
                                     want.contig_id, out_data.contig_id,
                                     want.scaffold_id, out_data.scaffold_id,
                                     want.begin_offset, out_data.begin_offset);
                            $display("  end %0d/%0d last %b/%b",
                                     want.end_offset, out_data.end_offset,
                                     want.last, out_data.last);
                        end
                    end
                end
            end
            due_count <= due_results.size();
        end
        fault_count <= faults;
    end

endmodule

>>> tb/sequence_gap_splitter_top_test.sv
module sequence_gap_splitter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // receiver back-pressure long enough to fill the job queue behind it
    localparam int HOLD_OFF_CYCLES = 300;
    // quiet time after the last result: covers items still in flight that
    // produce nothing (the block holds at most two queued jobs)
    localparam int SETTLE_CYCLES   = 16;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [6:0]         cfg_wdata = '0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    sgs_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    sgs_pkg::out_item_t out_data;

    int        due_count;
    int        fault_count;

    // idle rates in percent, changed per phase; 0 means back-to-back
    int        src_idle_pct  = 0;
    int        snk_stall_pct = 0;
    int        hold_reqs     = 0;
    int        items_sent    = 0;

    sequence_gap_splitter_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // predicts every result and compares; hands back what is still due
    contig_stream_checker stream_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .due_count   (due_count),
        .fault_count (fault_count)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Safety net well past the slowest legal run.
    initial
    begin
        #80_000_000;
        $display("sequence_gap_splitter_top_test: FAIL");
        $finish;
    end

    // Gap length: mostly from a short range, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Receiver. Random stalls at the phase's rate; on request a long
    // hold-off, counted here, so the block backs up into its input.
    // ------------------------------------------------------------------
    initial
    begin
        int gap_left;
        int hold_left;
        int hold_seen;
        gap_left  = 0;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 99) < snk_stall_pct)
                    gap_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one item and hold it until taken. Valid only drops when a gap
    // follows, so back-to-back items never toggle it within a step.
    task automatic send(input logic cmd, input logic [7:0] b);
        int gap;
        in_valid <= 1'b1;
        in_data  <= {cmd, b};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            gap = pick_gap();
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        send(sgs_pkg::CMD_BYTE, b);
    endtask

    // byte field is a don't-care on end of input; randomize it anyway
    task automatic push_end();
        send(sgs_pkg::CMD_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Stop sending and wait for every predicted result, then a quiet settle
    // time. Leaves the block idle, so a register write may follow.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_count != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [6:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random text
    // ------------------------------------------------------------------
    function automatic logic [7:0] base_byte();
        string bases;
        bases = "ACGTacgt";
        return bases[$urandom_range(0, 7)];
    endfunction

    // non-ACGT symbols; the high range covers bytes with the top bit set
    function automatic logic [7:0] bad_byte();
        case ($urandom_range(0, 5))
            0: return sgs_pkg::CH_N;
            1: return "n";
            2: return sgs_pkg::CH_GT;
            3: return "-";
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // whitespace or NUL: ignored, no offset advance
    function automatic logic [7:0] filler_byte();
        case ($urandom_range(0, 6))
            0: return sgs_pkg::CH_SP;
            1: return sgs_pkg::CH_TAB;
            2: return sgs_pkg::CH_LF;
            3: return sgs_pkg::CH_VT;
            4: return sgs_pkg::CH_FF;
            5: return sgs_pkg::CH_CR;
            default: return sgs_pkg::CH_NUL;
        endcase
    endfunction

    // header text: anything but a line feed
    function automatic logic [7:0] name_byte();
        logic [7:0] r;
        r = 8'($urandom_range(0, 255));
        return (r == sgs_pkg::CH_LF) ? "_" : r;
    endfunction

    // Bad-run length: short ones, and around the split point where the
    // threshold is low enough to reach cheaply.
    function automatic int bad_len(input int eff);
        int n;
        if (eff <= 8 && $urandom_range(0, 1) == 0)
            n = eff - 1 + $urandom_range(0, 2);
        else if ($urandom_range(0, 9) == 0)
            n = $urandom_range(8, 20);
        else
            n = $urandom_range(1, 3);
        return (n < 1) ? 1 : n;
    endfunction

    // A symbol, sometimes preceded by whitespace, NUL or a line break.
    // After a line break a '>' symbol turns into a header, on purpose.
    task automatic push_sym(input logic [7:0] b);
        if ($urandom_range(0, 9) == 0)
            push_byte(filler_byte());
        push_byte(b);
    endtask

    // One scaffold: usually a header line, then runs of bases split by bad
    // runs. Sometimes the header is missing or the input ends here.
    task automatic gen_scaffold(input int eff);
        int n;
        if ($urandom_range(0, 9) != 0)
        begin
            push_byte(sgs_pkg::CH_GT);
            n = $urandom_range(0, 4);
            repeat (n) push_byte(name_byte());
            push_byte(sgs_pkg::CH_LF);
        end
        n = $urandom_range(1, 3);
        repeat (n)
        begin
            repeat ($urandom_range(1, 4)) push_sym(base_byte());
            if ($urandom_range(0, 4) != 0)
                repeat (bad_len(eff)) push_sym(bad_byte());
        end
        push_byte(sgs_pkg::CH_LF);
        if ($urandom_range(0, 6) == 0)
            push_end();
    endtask

    task automatic random_phase(input logic [6:0] setting, input int budget);
        int eff;
        int start;
        eff = (setting == 7'd0) ? 1 : ((setting > 7'd64) ? 64 : int'(setting));
        write_cfg(setting);
        start = items_sent;
        while (items_sent - start < budget)
            gen_scaffold(eff);
        push_end();
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset threshold of 2, no idling on either side.
        push_byte("A");             // base before any header
        push_byte(8'hFF);           // all-ones byte, bad symbol
        push_text(">g\n");          // '>' mid-line is bad: run of 2 splits, no header yet
        push_text(">x\n");          // first header: open only, name skipped
        push_byte(sgs_pkg::CH_NUL); // NUL ignored
        push_text("N\tC?a\r\n");    // leading N dropped, tab skipped, short run -> N
        push_text(">\n> \n");       // back-to-back headers: empty scaffold close
        push_byte(sgs_pkg::CH_VT);
        push_byte("T");
        push_end();                 // closes the last contig
        push_end();                 // nothing seen since: no result
        drain();

        // Threshold past the ceiling acts as 64: the longest N burst, 63
        // symbols plus its base. The receiver holds off at the start so the
        // queue fills and input stalls.
        src_idle_pct  = 10;
        snk_stall_pct = 20;
        write_cfg(7'd127);
        hold_reqs++;
        push_text(">sat\nA");
        repeat (63) push_byte(bad_byte());
        push_byte("C");
        push_text("G\n");
        push_end();
        drain();

        // Random phases over the register range, idle rates varied,
        // including a stretch with no idling at all.
        src_idle_pct  = 30;
        snk_stall_pct = 30;
        random_phase(7'd0, 8);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        random_phase(7'd64, 8);
        src_idle_pct  = 20;
        snk_stall_pct = 15;
        random_phase(7'd1, 8);
        src_idle_pct  = 25;
        snk_stall_pct = 25;
        random_phase(7'($urandom_range(2, 8)), 8);
        src_idle_pct  = 10;
        snk_stall_pct = 40;
        random_phase(7'($urandom_range(65, 126)), 8);

        if (fault_count == 0 && due_count == 0)
            $display("sequence_gap_splitter_top_test: PASS");
        else
            $display("sequence_gap_splitter_top_test: FAIL");
        $finish;
    end

endmodule
